[hdl/hts_pkg.sv]
// Shared constants, operation codes and the CRC-8 byte update for the sensor target.
package hts_pkg;

  // Bus event codes carried on the operation field.
  localparam logic [1:0] OP_ADDRESS = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_HUMIDITY    = 1'b0;
  localparam logic CFG_TEMPERATURE = 1'b1;

  localparam logic [6:0]  DEVICE_ADDRESS  = 7'h38;
  localparam logic [7:0]  CMD_SOFT_RESET  = 8'hBA;
  localparam logic [7:0]  CMD_INIT        = 8'hBE;
  localparam logic [7:0]  CMD_MEASURE_0   = 8'h00;
  localparam logic [7:0]  CMD_MEASURE_1   = 8'hAC;
  localparam logic [7:0]  CMD_MEASURE_2   = 8'h33;
  localparam logic [7:0]  STATUS_IDLE     = 8'h18;
  localparam logic [7:0]  CRC_POLY        = 8'h31;
  localparam logic [7:0]  CRC_INIT        = 8'hFF;
  localparam logic [19:0] HUMIDITY_RESET  = 20'd681574;
  localparam logic [19:0] TEMP_RESET      = 20'd367001;

  // Number of frame bytes covered by the checksum.
  localparam int unsigned CRC_BYTES = 6;

  // One byte of the MSB-first CRC-8 with polynomial 0x31.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/hts_crc.sv]
// Combinational CRC-8 over the six leading frame bytes.
module hts_crc (
  input  logic [47:0] frame_i,
  output logic [7:0]  crc_o
);
  import hts_pkg::*;

  // Byte zero sits in the top bits of the frame vector; all six bytes are folded in at once.
  always_comb begin
    logic [7:0] c;
    c = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) begin
      c = crc8_update(c, frame_i[47 - 8 * i -: 8]);
    end
    crc_o = c;
  end

endmodule

[hdl/humidity_temp_sensor_i2c_target_unit.sv]
// Top level of the humidity and temperature sensor bus target.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o | operation_i, address_i, data_i
//  out     | output    | out_valid_o / out_stall_i | ack_o, read_data_o
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// Each word is decoded in the cycle it is accepted and its result is registered, so a
// word can be taken every cycle while the output is not stalled and its result appears in the next cycle.
// The frame checksum is computed in the same cycle as the measure command completes
// and is stored with the frame, so every frame byte can be read right away.
// Reset clears the control state and loads the default sensor codes.
// A new word is taken whenever the result register is empty or is being taken.
module humidity_temp_sensor_i2c_target_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [6:0]  address_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ack_o,
  output logic [7:0]  read_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import hts_pkg::*;

  logic [19:0] humidity_q, temperature_q;
  logic        measuring_q, measuring_d;
  logic [2:0]  read_ptr_q, read_ptr_d;
  logic [1:0]  write_count_q, write_count_d;
  logic [7:0]  cmd_q [2];
  logic [55:0] frame_q;
  logic        out_valid_q;
  logic        ack_q, ack_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        in_accept;
  logic        capture;
  logic        cmd_wr;
  logic        cmd_pos;
  logic [1:0]  pos;
  logic [47:0] frame_head;
  logic [7:0]  crc;
  logic [7:0]  frame_byte;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      humidity_q    <= HUMIDITY_RESET;
      temperature_q <= TEMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HUMIDITY:    humidity_q    <= cfg_data_i;
        CFG_TEMPERATURE: temperature_q <= cfg_data_i;
        default:         humidity_q    <= humidity_q;
      endcase
    end
  end

  // Frame byte at the read pointer; byte six is the checksum.
  always_comb begin
    case (read_ptr_q)
      3'd0:    frame_byte = frame_q[55:48];
      3'd1:    frame_byte = frame_q[47:40];
      3'd2:    frame_byte = frame_q[39:32];
      3'd3:    frame_byte = frame_q[31:24];
      3'd4:    frame_byte = frame_q[23:16];
      3'd5:    frame_byte = frame_q[15:8];
      default: frame_byte = frame_q[7:0];
    endcase
  end

  // Decode of one bus event.
  always_comb begin
    measuring_d   = measuring_q;
    read_ptr_d    = read_ptr_q;
    write_count_d = write_count_q;
    ack_d         = 1'b0;
    rdata_d       = 8'h00;
    capture       = 1'b0;
    cmd_wr        = 1'b0;
    pos           = (write_count_q == 2'd3) ? 2'd2 : write_count_q;
    cmd_pos       = pos[0];
    case (operation_i)
      OP_ADDRESS: begin
        if (measuring_q) begin
          read_ptr_d = 3'd0;
        end
        ack_d = (address_i == DEVICE_ADDRESS);
      end
      OP_WRITE: begin
        ack_d         = 1'b1;
        cmd_wr        = (pos != 2'd2);
        write_count_d = pos + 2'd1;
        if (pos == 2'd0 && data_i == CMD_SOFT_RESET) begin
          measuring_d   = 1'b0;
          write_count_d = 2'd0;
        end else if (pos == 2'd2) begin
          // A third byte always closes the command.
          write_count_d = 2'd0;
          if (cmd_q[0] != CMD_INIT && cmd_q[0] == CMD_MEASURE_0 &&
              cmd_q[1] == CMD_MEASURE_1 && data_i == CMD_MEASURE_2) begin
            measuring_d = 1'b1;
            capture     = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (!measuring_q) begin
          rdata_d = STATUS_IDLE;
        end else if (read_ptr_q != 3'd7) begin
          rdata_d    = frame_byte;
          read_ptr_d = read_ptr_q + 3'd1;
        end else begin
          measuring_d = 1'b0;
          read_ptr_d  = 3'd0;
        end
      end
      default: begin
        ack_d = 1'b0;
      end
    endcase
  end

  // Control state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      measuring_q   <= 1'b0;
      read_ptr_q    <= 3'd0;
      write_count_q <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        measuring_q   <= measuring_d;
        read_ptr_q    <= read_ptr_d;
        write_count_q <= write_count_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Status and sensor codes as they enter the frame, and their checksum.
  assign frame_head = {STATUS_IDLE, humidity_q, temperature_q};

  hts_crc u_crc (
    .frame_i (frame_head),
    .crc_o   (crc)
  );

  // Command bytes, frame capture and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ack_q   <= ack_d;
      rdata_q <= rdata_d;
      if (cmd_wr) begin
        cmd_q[cmd_pos] <= data_i;
      end
      if (capture) begin
        frame_q <= {frame_head, crc};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign ack_o       = ack_q;
  assign read_data_o = rdata_q;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted word produced no result");
  a_empty_not_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");
  a_write_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_count_q != 2'd3)
    else $error("command byte count reached an unused value");
  a_capture_sets_measuring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && capture |=> measuring_q)
    else $error("measure command did not start a measurement");
`endif

endmodule
